// ===== rtl/midi_mono_note_tracker_macros.svh =====
// Assertion macros shared by the note tracker RTL.
`ifndef MIDI_MONO_NOTE_TRACKER_MACROS_SVH
`define MIDI_MONO_NOTE_TRACKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MMNT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MMNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mmnt_pkg.sv =====
// Shared types and constants for the MIDI mono note tracker.
package mmnt_pkg;

  localparam int NUM_NOTES_DEF = 128;
  localparam int NOTE_W        = 7;
  localparam int BEND_W        = 14;
  localparam int WHEEL_W       = 7;

  // Upper nibble of the status byte
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CTRL     = 4'hB;
  localparam logic [3:0] KIND_BEND     = 4'hE;

  localparam logic [NOTE_W-1:0] CC_MOD_WHEEL  = 7'd1;
  localparam logic [NOTE_W-1:0] HELD_NOTE_RST = 7'd60;
  // Subtracting the center (0x2000) in 14 bits flips the top bit
  localparam logic [BEND_W-1:0] BEND_CENTER   = 14'h2000;

  typedef struct packed {
    logic              found;
    logic [NOTE_W-1:0] note;
  } note_pick_t;

endpackage

// ===== rtl/mmnt_prio_enc.sv =====
// Lowest-set-bit priority encoder over the pressed-note map.
module mmnt_prio_enc #(
  parameter int NUM_NOTES = mmnt_pkg::NUM_NOTES_DEF
) (
  input  logic [NUM_NOTES-1:0] note_map,
  output mmnt_pkg::note_pick_t pick
);
  import mmnt_pkg::*;

  logic [NUM_NOTES-1:0] lowest;
  logic [NOTE_W-1:0]    note_idx;

  // Isolate the lowest set bit, then OR-encode its position
  assign lowest = note_map & (~note_map + {{(NUM_NOTES-1){1'b0}}, 1'b1});

  always_comb begin
    note_idx = '0;
    for (int i = 0; i < NUM_NOTES; i++) begin
      note_idx = note_idx | ({NOTE_W{lowest[i]}} & NOTE_W'(i));
    end
  end

  assign pick.found = |note_map;
  assign pick.note  = note_idx;

endmodule

// ===== rtl/midi_mono_note_tracker.sv =====
// MIDI mono note tracker: lowest-note priority, pitch bend and mod wheel state.
// Takes one 3-byte channel message per request (channel nibble ignored) and
// returns one result per request with the state after that message: the
// lowest pressed note (or the last held one when none is pressed), the gate, the
// signed pitch bend offset and the mod wheel value. A request is registered
// on input, then resolved by a priority encoder over the pressed-note map,
// which writes the state registers that drive the result ports; the result
// is valid once the state registers are written from the input register,
// and a new request is taken every cycle while results are being consumed.
// A result that waits holds the state registers, so the input register
// fills and the input stalls until the result is taken.
module midi_mono_note_tracker #(
  parameter int NUM_NOTES = mmnt_pkg::NUM_NOTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          status_byte,
  input  logic [mmnt_pkg::NOTE_W-1:0]         data_byte_1,
  input  logic [mmnt_pkg::NOTE_W-1:0]         data_byte_2,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mmnt_pkg::NOTE_W-1:0]         current_note,
  output logic                                gate_on,
  output logic signed [mmnt_pkg::BEND_W-1:0]  bend_value,
  output logic [mmnt_pkg::WHEEL_W-1:0]        wheel_value
);
  import mmnt_pkg::*;
  `include "midi_mono_note_tracker_macros.svh"

  localparam int IDX_W = $clog2(NUM_NOTES);

  // Input stage
  logic              s1_valid;
  logic [3:0]        s1_kind;
  logic [NOTE_W-1:0] s1_d1;
  logic [NOTE_W-1:0] s1_d2;

  // Tracker state; the result ports read it directly
  logic [NUM_NOTES-1:0] pressed_map;
  logic [NUM_NOTES-1:0] pressed_map_next;
  logic [NOTE_W-1:0]    held_note;
  logic                 gate_flag;
  logic [BEND_W-1:0]    bend_reg;
  logic [WHEEL_W-1:0]   wheel_reg;

  logic       advance;
  logic       in_range;
  note_pick_t pick;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  assign in_range = {1'b0, s1_d1} < 8'(NUM_NOTES);

  always_comb begin
    pressed_map_next = pressed_map;
    if (in_range) begin
      unique case (s1_kind)
        KIND_NOTE_ON:  pressed_map_next[s1_d1[IDX_W-1:0]] = (s1_d2 != '0);
        KIND_NOTE_OFF: pressed_map_next[s1_d1[IDX_W-1:0]] = 1'b0;
        default:       pressed_map_next = pressed_map;
      endcase
    end
  end

  mmnt_prio_enc #(
    .NUM_NOTES(NUM_NOTES)
  ) u_prio_enc (
    .note_map(pressed_map_next),
    .pick    (pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_kind <= status_byte[7:4];
      s1_d1   <= data_byte_1;
      s1_d2   <= data_byte_2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      pressed_map <= '0;
      held_note   <= HELD_NOTE_RST;
      gate_flag   <= 1'b0;
      bend_reg    <= '0;
      wheel_reg   <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        // Unchanged map repicks the same note, so other messages are harmless here
        pressed_map <= pressed_map_next;
        gate_flag   <= pick.found;
        if (pick.found) begin
          held_note <= pick.note;
        end
        unique case (s1_kind)
          KIND_BEND: bend_reg <= {s1_d2, s1_d1} ^ BEND_CENTER;
          KIND_CTRL: begin
            if (s1_d1 == CC_MOD_WHEEL) begin
              wheel_reg <= s1_d2;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign current_note = held_note;
  assign gate_on      = gate_flag;
  assign bend_value   = $signed(bend_reg);
  assign wheel_value  = wheel_reg;

  `MMNT_ASSERT_NOW(a_gate_matches_map, 1'b1, gate_flag == (|pressed_map), "gate/map mismatch")
  `MMNT_ASSERT_NOW(a_held_note_pressed, gate_flag, pressed_map[held_note[IDX_W-1:0]], "held note not pressed")
  `MMNT_ASSERT_NEXT(a_stalled_request_kept, s1_valid && !advance, s1_valid, "request dropped")
  `MMNT_ASSERT_NEXT(a_bend_loaded, advance && (s1_kind == KIND_BEND), (bend_reg ^ BEND_CENTER) == {$past(s1_d2), $past(s1_d1)}, "bend not stored")

endmodule
